// ===== design/pqr_pkg.sv =====
// shared constants and register codes for the point-in-quad region filter
// no dependencies; imported by the interfaces and every module of the block
package pqr_pkg;

   localparam int COORD_BITS_DEF = 20;
   localparam int NUM_CORNERS    = 4;
   localparam int CSR_INDEX_BITS = 4;

   // csr register map, one code per corner coordinate
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CORNER0_X = 4'd0,
      REG_CORNER0_Y = 4'd1,
      REG_CORNER1_X = 4'd2,
      REG_CORNER1_Y = 4'd3,
      REG_CORNER2_X = 4'd4,
      REG_CORNER2_Y = 4'd5,
      REG_CORNER3_X = 4'd6,
      REG_CORNER3_Y = 4'd7
   } csr_reg_type;

endpackage

// ===== design/pqr_req_if.sv =====
// point input channel: valid/ready handshake with one point per beat
// depends on pqr_pkg for the default coordinate width
interface pqr_req_if import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== design/pqr_rsp_if.sv =====
// kept point output channel: valid/ready handshake with one point per beat
// depends on pqr_pkg for the default coordinate width
interface pqr_rsp_if import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] kept_x;
   logic signed [COORD_BITS-1:0] kept_y;

   modport source (output valid, output kept_x, output kept_y, input ready);
   modport sink   (input valid, input kept_x, input kept_y, output ready);
endinterface

// ===== design/pqr_csr_if.sv =====
// configuration write channel: register index and data per beat
// depends on pqr_pkg for index width and default coordinate width
interface pqr_csr_if import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pqr_csr.sv =====
// corner registers of the region, written through the csr channel
// depends on pqr_pkg and pqr_csr_if
module pqr_csr import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   pqr_csr_if.sink                      csr,
   output logic signed [COORD_BITS-1:0] corner_x [NUM_CORNERS],
   output logic signed [COORD_BITS-1:0] corner_y [NUM_CORNERS]
);

   logic signed [COORD_BITS-1:0] cx_ff [NUM_CORNERS];
   logic signed [COORD_BITS-1:0] cy_ff [NUM_CORNERS];
   logic signed [COORD_BITS-1:0] cx_in [NUM_CORNERS];
   logic signed [COORD_BITS-1:0] cy_in [NUM_CORNERS];

   assign csr.ready = 1'b1;

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      if (csr.valid) begin
         // indexes past the last corner fall to default and are dropped
         unique case (csr.index)
            REG_CORNER0_X: cx_in[0] = $signed(csr.data);
            REG_CORNER0_Y: cy_in[0] = $signed(csr.data);
            REG_CORNER1_X: cx_in[1] = $signed(csr.data);
            REG_CORNER1_Y: cy_in[1] = $signed(csr.data);
            REG_CORNER2_X: cx_in[2] = $signed(csr.data);
            REG_CORNER2_Y: cy_in[2] = $signed(csr.data);
            REG_CORNER3_X: cx_in[3] = $signed(csr.data);
            REG_CORNER3_Y: cy_in[3] = $signed(csr.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            cx_ff[k] <= '0;
            cy_ff[k] <= '0;
         end
      end else begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   assign corner_x = cx_ff;
   assign corner_y = cy_ff;

endmodule

// ===== design/pqr_diff.sv =====
// stage 1: per-edge coordinate differences and y straddle test
// depends on pqr_pkg and pqr_req_if
module pqr_diff import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   pqr_req_if.sink                      req,
   input  logic signed [COORD_BITS-1:0] corner_x [NUM_CORNERS],
   input  logic signed [COORD_BITS-1:0] corner_y [NUM_CORNERS],
   input  logic                         down_ready,
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] out_px,
   output logic signed [COORD_BITS-1:0] out_py,
   output logic signed [COORD_BITS:0]   out_dxp [NUM_CORNERS],
   output logic signed [COORD_BITS:0]   out_dyp [NUM_CORNERS],
   output logic signed [COORD_BITS:0]   out_dxe [NUM_CORNERS],
   output logic signed [COORD_BITS:0]   out_dye [NUM_CORNERS],
   output logic [NUM_CORNERS-1:0]       out_straddle
);

   localparam int DW = COORD_BITS + 1;

   logic                         valid_ff;
   logic                         load;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [DW-1:0]         dxp_ff [NUM_CORNERS], dxp_in [NUM_CORNERS];
   logic signed [DW-1:0]         dyp_ff [NUM_CORNERS], dyp_in [NUM_CORNERS];
   logic signed [DW-1:0]         dxe_ff [NUM_CORNERS], dxe_in [NUM_CORNERS];
   logic signed [DW-1:0]         dye_ff [NUM_CORNERS], dye_in [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]       straddle_ff, straddle_in;

   assign req.ready = !valid_ff || down_ready;
   assign load      = req.valid && req.ready;

   // edge e runs from corner e to the corner before it
   for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
      localparam int J = (e + NUM_CORNERS - 1) % NUM_CORNERS;
      assign dxp_in[e] = DW'(req.point_x) - DW'(corner_x[e]);
      assign dyp_in[e] = DW'(req.point_y) - DW'(corner_y[e]);
      assign dxe_in[e] = DW'(corner_x[J]) - DW'(corner_x[e]);
      assign dye_in[e] = DW'(corner_y[J]) - DW'(corner_y[e]);
      assign straddle_in[e] = (corner_y[e] > req.point_y) != (corner_y[J] > req.point_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req.ready) begin
         valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff       <= req.point_x;
         py_ff       <= req.point_y;
         dxp_ff      <= dxp_in;
         dyp_ff      <= dyp_in;
         dxe_ff      <= dxe_in;
         dye_ff      <= dye_in;
         straddle_ff <= straddle_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_px       = px_ff;
   assign out_py       = py_ff;
   assign out_dxp      = dxp_ff;
   assign out_dyp      = dyp_ff;
   assign out_dxe      = dxe_ff;
   assign out_dye      = dye_ff;
   assign out_straddle = straddle_ff;

endmodule

// ===== design/pqr_mul.sv =====
// stage 2: the two cross products of every edge, one multiplier pair per edge
// depends on pqr_pkg
module pqr_mul import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS-1:0]   in_px,
   input  logic signed [COORD_BITS-1:0]   in_py,
   input  logic signed [COORD_BITS:0]     in_dxp [NUM_CORNERS],
   input  logic signed [COORD_BITS:0]     in_dyp [NUM_CORNERS],
   input  logic signed [COORD_BITS:0]     in_dxe [NUM_CORNERS],
   input  logic signed [COORD_BITS:0]     in_dye [NUM_CORNERS],
   input  logic [NUM_CORNERS-1:0]         in_straddle,
   input  logic                           down_ready,
   output logic                           out_valid,
   output logic signed [COORD_BITS-1:0]   out_px,
   output logic signed [COORD_BITS-1:0]   out_py,
   output logic signed [2*COORD_BITS+1:0] out_lhs [NUM_CORNERS],
   output logic signed [2*COORD_BITS+1:0] out_rhs [NUM_CORNERS],
   output logic [NUM_CORNERS-1:0]         out_straddle,
   output logic [NUM_CORNERS-1:0]         out_dy_neg
);

   localparam int PW = 2 * COORD_BITS + 2;

   logic                         valid_ff;
   logic                         load;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [PW-1:0]         lhs_ff [NUM_CORNERS], lhs_in [NUM_CORNERS];
   logic signed [PW-1:0]         rhs_ff [NUM_CORNERS], rhs_in [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]       straddle_ff, dy_neg_ff, dy_neg_in;

   assign in_ready = !valid_ff || down_ready;
   assign load     = in_valid && in_ready;

   for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_edge
      assign lhs_in[e]    = PW'(in_dxp[e]) * PW'(in_dye[e]);
      assign rhs_in[e]    = PW'(in_dxe[e]) * PW'(in_dyp[e]);
      assign dy_neg_in[e] = in_dye[e][COORD_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff       <= in_px;
         py_ff       <= in_py;
         lhs_ff      <= lhs_in;
         rhs_ff      <= rhs_in;
         straddle_ff <= in_straddle;
         dy_neg_ff   <= dy_neg_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_px       = px_ff;
   assign out_py       = py_ff;
   assign out_lhs      = lhs_ff;
   assign out_rhs      = rhs_ff;
   assign out_straddle = straddle_ff;
   assign out_dy_neg   = dy_neg_ff;

endmodule

// ===== design/point_in_quad_region_filter.sv =====
// Point-in-quadrilateral filter: each point beat on req is tested against the
// four corners held in the csr registers with the even-odd ray-casting rule,
// and only points found inside appear on rsp, unchanged. A req beat passes the
// difference stage, the product stage and the compare-and-parity into the
// output register. Unless rsp stalls, one point is accepted every clock, the
// rate set by the two multipliers per edge in the product stage, which take a
// new operand set each cycle. Points outside the region are dropped without a
// rsp beat. A stall on rsp backs up stage by stage, so req.ready falls only
// once all three stages hold points. Corners reset to zero, which keeps no
// point; write them only while no point is in flight.
// depends on pqr_pkg, the three channel interfaces, pqr_csr, pqr_diff, pqr_mul
module point_in_quad_region_filter import pqr_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pqr_req_if.sink    req,
   pqr_rsp_if.source  rsp,
   pqr_csr_if.sink    csr
);

   localparam int PW = 2 * COORD_BITS + 2;

   // corner registers
   logic signed [COORD_BITS-1:0] corner_x [NUM_CORNERS];
   logic signed [COORD_BITS-1:0] corner_y [NUM_CORNERS];

   // stage 1 outputs
   logic                         d_valid, d_ready;
   logic signed [COORD_BITS-1:0] d_px, d_py;
   logic signed [COORD_BITS:0]   d_dxp [NUM_CORNERS];
   logic signed [COORD_BITS:0]   d_dyp [NUM_CORNERS];
   logic signed [COORD_BITS:0]   d_dxe [NUM_CORNERS];
   logic signed [COORD_BITS:0]   d_dye [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]       d_straddle;

   // stage 2 outputs
   logic                         m_valid, m_ready;
   logic signed [COORD_BITS-1:0] m_px, m_py;
   logic signed [PW-1:0]         m_lhs [NUM_CORNERS];
   logic signed [PW-1:0]         m_rhs [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]       m_straddle, m_dy_neg;

   // output register
   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] kept_x_ff, kept_y_ff;
   logic                         out_free;
   logic [NUM_CORNERS-1:0]       crossing;
   logic                         keep;

   pqr_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .corner_x (corner_x),
      .corner_y (corner_y)
   );

   pqr_diff #(.COORD_BITS(COORD_BITS)) u_diff (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .corner_x     (corner_x),
      .corner_y     (corner_y),
      .down_ready   (d_ready),
      .out_valid    (d_valid),
      .out_px       (d_px),
      .out_py       (d_py),
      .out_dxp      (d_dxp),
      .out_dyp      (d_dyp),
      .out_dxe      (d_dxe),
      .out_dye      (d_dye),
      .out_straddle (d_straddle)
   );

   pqr_mul #(.COORD_BITS(COORD_BITS)) u_mul (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (d_valid),
      .in_ready     (d_ready),
      .in_px        (d_px),
      .in_py        (d_py),
      .in_dxp       (d_dxp),
      .in_dyp       (d_dyp),
      .in_dxe       (d_dxe),
      .in_dye       (d_dye),
      .in_straddle  (d_straddle),
      .down_ready   (m_ready),
      .out_valid    (m_valid),
      .out_px       (m_px),
      .out_py       (m_py),
      .out_lhs      (m_lhs),
      .out_rhs      (m_rhs),
      .out_straddle (m_straddle),
      .out_dy_neg   (m_dy_neg)
   );

   // an edge crosses when it straddles py and px lies left of its crossing;
   // with dy negative the cross-multiplied comparison flips sense
   for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_cross
      assign crossing[e] = m_straddle[e] &&
                           (m_dy_neg[e] ? (m_rhs[e] < m_lhs[e]) : (m_lhs[e] < m_rhs[e]));
   end

   // odd crossing count means inside
   assign keep = ^crossing;

   // the output register is free when empty or being drained this cycle;
   // a point that is not kept leaves stage 2 without needing it
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign m_ready  = out_free || !keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= m_valid && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && m_valid && keep) begin
         kept_x_ff <= m_px;
         kept_y_ff <= m_py;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.kept_x = kept_x_ff;
   assign rsp.kept_y = kept_y_ff;

`ifndef SYNTHESIS
   // nothing shows on rsp in the cycle after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp valid after reset");

   // a new rsp beat comes only from a point that sat in the product stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(m_valid))
      else $error("rsp beat without a point in the product stage");

   // a kept point stalled in the product stage is still there next cycle
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      m_valid && !m_ready |=> m_valid && $stable(m_px) && $stable(m_py))
      else $error("stalled point lost in the product stage");

   // stage 1 never loses a point when stage 2 cannot take it
   a_diff_hold: assert property (@(posedge clock) disable iff (reset)
      d_valid && !d_ready |=> d_valid && $stable(d_px) && $stable(d_py))
      else $error("stalled point lost in the difference stage");
`endif

endmodule
